### src/assert_macros.svh
// Assertion macros shared by the event FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a trigger implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

### src/lleq_pkg.sv
// Types and constants for the linked-list event FIFO.
`default_nettype none
package lleq_pkg;

    // Field widths of one event
    localparam int TYPE_W   = 8;
    localparam int STAMP_W  = 64;
    localparam int SOURCE_W = 32;
    localparam int QUEUED_W = 6;
    localparam int DATA_W   = TYPE_W + STAMP_W + SOURCE_W;

    // Stream widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 112;

    // Action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_DATA
    } t_state;

endpackage
`default_nettype wire

### src/lleq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lleq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### src/linked_list_event_fifo.sv
// Top level of the linked-list event FIFO: sequencer, pointers and memories.
//
// Events are held in a singly linked list over a pool of POOL_ENTRIES entries,
// with a sentinel at the head and the unused entries on a free list. The link
// memory and the event memory are synchronous RAMs with registered read data,
// and one item is handled at a time. A push reads the link of the free entry,
// then writes the event and the tail link. A poll reads the link of the
// sentinel, then reads the next node's event, then presents it, since the
// event address comes out of the link memory. A failed push or poll only
// reads a link before its result is presented. After reset the link memory
// is initialised one entry per cycle, so no input is taken until every entry
// is chained. The result sits in an output register, so a new input is taken
// while an earlier result still waits on the master side.
`default_nettype none
module linked_list_event_fifo #(
    parameter int POOL_ENTRIES = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: in_type[7:0], in_timestamp[71:8], in_source[103:72]
    input  wire logic [lleq_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: action[0]
    input  wire logic                            i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: out_type[7:0], out_timestamp[71:8], out_source[103:72],
    //        queued[109:104], zero[111:110]
    output logic [lleq_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // tuser: ok[0]
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready
);

    import lleq_pkg::*;

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(POOL_ENTRIES);

    // Control state
    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_clr_idx, n_clr_idx;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_free_ptr, n_free_ptr;
    logic [PTR_W-1:0] r_free_left, n_free_left;
    logic [PTR_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // Captured item
    logic                r_act;
    logic                r_ok;
    logic [TYPE_W-1:0]   r_type;
    logic [STAMP_W-1:0]  r_stamp;
    logic [SOURCE_W-1:0] r_src;

    // Output register
    logic                r_out_ok, n_out_ok;
    logic [TYPE_W-1:0]   r_out_type, n_out_type;
    logic [STAMP_W-1:0]  r_out_stamp, n_out_stamp;
    logic [SOURCE_W-1:0] r_out_src, n_out_src;
    logic [QUEUED_W-1:0] r_out_queued, n_out_queued;

    // Memory ports
    logic             link_we, link_re;
    logic [PTR_W-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic             data_we, data_re;
    logic [PTR_W-1:0] data_waddr, data_raddr;
    logic [DATA_W-1:0] data_wdata, data_rdata;

    logic             w_in_acc;
    logic             w_in_act;
    logic [TYPE_W-1:0] w_in_type;
    logic             w_in_ok;
    logic             w_out_free;
    logic             w_load;
    logic [PTR_W-1:0] w_clr_next;
    logic [PTR_W+QUEUED_W-1:0] w_count_ext, w_cur_ext;

    lleq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    lleq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POOL_ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    // Handshakes and input decode
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_act        = i_s_axis_tuser;
    assign w_in_type       = i_s_axis_tdata[TYPE_W-1:0];
    assign w_in_ok         = (w_in_act == ACT_POLL) ? (r_count != '0)
                           : ((w_in_type != '0) && (r_free_left != '0));
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_clr_next      = (r_clr_idx == PTR_W'(POOL_ENTRIES - 1)) ? '0
                           : r_clr_idx + PTR_W'(1);
    assign w_count_ext     = {{QUEUED_W{1'b0}}, n_count};
    assign w_cur_ext       = {{QUEUED_W{1'b0}}, r_count};

    // Sequencer: next state, pointer updates and memory accesses
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_ptr   = r_free_ptr;
        n_free_left  = r_free_left;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        w_load       = 1'b0;
        n_out_ok     = 1'b0;
        n_out_type   = '0;
        n_out_stamp  = '0;
        n_out_src    = '0;
        link_we      = 1'b0;
        link_waddr   = r_tail;
        link_wdata   = r_free_ptr;
        link_re      = 1'b0;
        link_raddr   = r_free_ptr;
        data_we      = 1'b0;
        data_waddr   = r_free_ptr;
        data_wdata   = {r_src, r_stamp, r_type};
        data_re      = 1'b0;
        data_raddr   = link_rdata;
        case (r_state)
            ST_CLEAR: begin
                // Chain every entry to the next one
                link_we    = 1'b1;
                link_waddr = r_clr_idx;
                link_wdata = w_clr_next;
                n_clr_idx  = w_clr_next;
                if (r_clr_idx == PTR_W'(POOL_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Fetch the link of the free head or of the sentinel
                if (w_in_acc) begin
                    link_re    = 1'b1;
                    link_raddr = (w_in_act == ACT_POLL) ? r_head : r_free_ptr;
                    n_state    = ST_LINK;
                end
            end
            ST_LINK: begin
                if (r_act == ACT_POLL && r_ok) begin
                    // Advance the head and return the old sentinel to the free list
                    data_re     = 1'b1;
                    link_we     = 1'b1;
                    link_waddr  = r_head;
                    link_wdata  = r_free_ptr;
                    n_head      = link_rdata;
                    n_free_ptr  = r_head;
                    n_free_left = r_free_left + PTR_W'(1);
                    n_count     = r_count - PTR_W'(1);
                    n_state     = ST_DATA;
                end else if (w_out_free) begin
                    if (r_act == ACT_PUSH && r_ok) begin
                        // Store the event and link it after the tail
                        data_we     = 1'b1;
                        link_we     = 1'b1;
                        n_free_ptr  = link_rdata;
                        n_free_left = r_free_left - PTR_W'(1);
                        n_tail      = r_free_ptr;
                        n_count     = r_count + PTR_W'(1);
                    end
                    w_load       = 1'b1;
                    n_out_ok     = r_ok;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_DATA: begin
                // Present the polled event
                if (w_out_free) begin
                    w_load      = 1'b1;
                    n_out_ok    = 1'b1;
                    n_out_type  = data_rdata[TYPE_W-1:0];
                    n_out_stamp = data_rdata[TYPE_W +: STAMP_W];
                    n_out_src   = data_rdata[TYPE_W+STAMP_W +: SOURCE_W];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_queued = (r_state == ST_DATA) ? w_cur_ext[QUEUED_W-1:0]
                                            : w_count_ext[QUEUED_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_free_ptr  <= PTR_W'(1);
            r_free_left <= PTR_W'(POOL_ENTRIES - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free_ptr  <= n_free_ptr;
            r_free_left <= n_free_left;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the item and load the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act   <= w_in_act;
            r_ok    <= w_in_ok;
            r_type  <= w_in_type;
            r_stamp <= i_s_axis_tdata[TYPE_W +: STAMP_W];
            r_src   <= i_s_axis_tdata[TYPE_W+STAMP_W +: SOURCE_W];
        end
        if (w_load) begin
            r_out_ok     <= n_out_ok;
            r_out_type   <= n_out_type;
            r_out_stamp  <= n_out_stamp;
            r_out_src    <= n_out_src;
            r_out_queued <= n_out_queued;
        end
    end

    // Drive the master side
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - QUEUED_W){1'b0}},
                              r_out_queued, r_out_src, r_out_stamp, r_out_type};

    // Every entry is either queued, free or the sentinel
    `ASSERT_CLK(a_pool_balance,
        ({1'b0, r_count} + {1'b0, r_free_left}) == (PTR_W + 1)'(POOL_ENTRIES - 1),
        "event count and free count do not cover the pool")
    // An empty queue has its sentinel as tail
    `ASSERT_CLK(a_empty_head_tail,
        (r_state != ST_CLEAR && r_count == '0) |-> (r_head == r_tail),
        "empty queue with head and tail apart")
    // A successful push makes the old free head the tail
    `ASSERT_NEXT(a_push_tail,
        r_state == ST_LINK && r_act == ACT_PUSH && r_ok && w_out_free,
        r_tail == $past(r_free_ptr),
        "pushed entry did not become the tail")
    // No item enters while the link memory is initialised
    `ASSERT_CLK(a_clear_blocks,
        (r_state == ST_CLEAR) |-> !o_s_axis_tready,
        "input taken during link initialisation")

endmodule
`default_nettype wire
